// ===== rtl/jtw_pkg.sv =====
`default_nettype none
package jtw_pkg;

   localparam int MaxDepthDefault  = 32;
   localparam int CharWidthDefault = 8;
   localparam int MaxUnits         = 12;
   localparam int QueueDepth       = 4;

   typedef enum logic [3:0] {
      TOK_OPEN_OBJ  = 4'd0,
      TOK_CLOSE_OBJ = 4'd1,
      TOK_OPEN_ARR  = 4'd2,
      TOK_CLOSE_ARR = 4'd3,
      TOK_NAME      = 4'd4,
      TOK_STRING    = 4'd5,
      TOK_RAW       = 4'd6,
      TOK_TRUE      = 4'd7,
      TOK_FALSE     = 4'd8,
      TOK_NULL      = 4'd9
   } tok_type;

   typedef enum logic [2:0] {
      EV_NONE  = 3'd0,
      EV_SOBJ  = 3'd1,
      EV_SARR  = 3'd2,
      EV_EOBJ  = 3'd3,
      EV_EARR  = 3'd4,
      EV_NAME  = 3'd5,
      EV_VALUE = 3'd6,
      EV_DONE  = 3'd7
   } event_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_NAME   = 2'd1,
      KIND_STRING = 2'd2,
      KIND_RAW    = 2'd3
   } kind_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;
   localparam logic [1:0] ST_DEEP  = 2'd3;

   // one classified item: up to twelve characters, their count, a status and a done flag
   typedef struct packed {
      logic [MaxUnits-1:0][7:0] units;
      logic [3:0]               count;
      logic [1:0]               status;
      logic                     done;
   } run_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v <= 4'd9) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
   endfunction

endpackage
`default_nettype wire

// ===== rtl/jtw_front.sv =====
`default_nettype none
module jtw_front #(
   parameter int MAX_DEPTH  = jtw_pkg::MaxDepthDefault,
   parameter int CHAR_WIDTH = jtw_pkg::CharWidthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pretty,
   input  wire logic                  take,
   input  wire logic [3:0]            req_type,
   input  wire logic [CHAR_WIDTH-1:0] code_unit,
   input  wire logic                  has_unit,
   input  wire logic                  first_unit,
   input  wire logic                  last_unit,
   output jtw_pkg::run_type           run
);
   localparam int LW = $clog2(MAX_DEPTH + 1);
   localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   jtw_pkg::event_type last_event_ff, last_event_in;
   jtw_pkg::kind_type  kind_ff, kind_in;
   logic [LW-1:0]      level_ff, level_in;
   logic [MAX_DEPTH-1:0] stack_ff;
   logic               push_en, top_arr;
   logic [IW-1:0]      top_idx, wr_idx;
   logic [7:0]         ch;
   logic               val_ok, nm_ok, comma;
   jtw_pkg::kind_type  kind;
   logic [1:0]         st;
   logic               lvl_zero_after;

   assign ch      = code_unit[7:0];
   assign top_idx = IW'(level_ff - LW'(1));
   assign wr_idx  = IW'(level_ff);
   assign top_arr = (level_ff != '0) && stack_ff[top_idx];

   // legality of the next token
   always_comb begin
      unique case (last_event_ff) inside
         jtw_pkg::EV_NONE, jtw_pkg::EV_NAME, jtw_pkg::EV_SARR: val_ok = 1'b1;
         jtw_pkg::EV_EARR, jtw_pkg::EV_EOBJ, jtw_pkg::EV_VALUE: val_ok = top_arr;
         default: val_ok = 1'b0;
      endcase
      nm_ok = (level_ff != '0) && !top_arr && (last_event_ff != jtw_pkg::EV_NAME);
      comma = (last_event_ff == jtw_pkg::EV_EARR) || (last_event_ff == jtw_pkg::EV_EOBJ)
           || (last_event_ff == jtw_pkg::EV_VALUE);
   end

   // classify and expand one token into its characters
   always_comb begin
      logic [3:0] n;
      logic [7:0] u [jtw_pkg::MaxUnits];
      n = '0;
      for (int i = 0; i < jtw_pkg::MaxUnits; i++) u[i] = 8'h00;
      st = jtw_pkg::ST_OK;
      kind = jtw_pkg::kind_type'(req_type[1:0] + 2'd1);
      last_event_in = last_event_ff;
      kind_in = kind_ff;
      level_in = level_ff;
      push_en = 1'b0;
      lvl_zero_after = 1'b0;
      if (last_event_ff == jtw_pkg::EV_DONE) begin
         st = jtw_pkg::ST_DONE;
      end else if (req_type > jtw_pkg::TOK_NULL) begin
         st = jtw_pkg::ST_BAD;
      end else if (req_type >= jtw_pkg::TOK_NAME && req_type <= jtw_pkg::TOK_RAW) begin
         if (first_unit) begin
            if (kind_ff != jtw_pkg::KIND_NONE) st = jtw_pkg::ST_BAD;
            else if (kind == jtw_pkg::KIND_NAME ? !nm_ok : !val_ok) st = jtw_pkg::ST_BAD;
            else begin
               if (comma) begin
                  u[n] = 8'h2C; n = n + 4'd1;
                  if (pretty) begin u[n] = 8'h20; n = n + 4'd1; end
               end
               if (kind != jtw_pkg::KIND_RAW) begin u[n] = 8'h22; n = n + 4'd1; end
            end
         end else if (kind_ff != kind) begin
            st = jtw_pkg::ST_BAD;
         end
         if (st == jtw_pkg::ST_OK) begin
            kind_in = kind;
            if (has_unit) begin
               if (kind == jtw_pkg::KIND_RAW) begin
                  u[n] = ch; n = n + 4'd1;
               end else begin
                  case (ch) inside
                     8'h22, 8'h5C: begin u[n] = 8'h5C; u[n+1] = ch; n = n + 4'd2; end
                     8'h08: begin u[n] = 8'h5C; u[n+1] = 8'h62; n = n + 4'd2; end
                     8'h0C: begin u[n] = 8'h5C; u[n+1] = 8'h66; n = n + 4'd2; end
                     8'h0A: begin u[n] = 8'h5C; u[n+1] = 8'h6E; n = n + 4'd2; end
                     8'h0D: begin u[n] = 8'h5C; u[n+1] = 8'h72; n = n + 4'd2; end
                     8'h09: begin u[n] = 8'h5C; u[n+1] = 8'h74; n = n + 4'd2; end
                     default: begin
                        if (ch <= 8'h1F) begin
                           u[n] = 8'h5C; u[n+1] = 8'h75; u[n+2] = 8'h30; u[n+3] = 8'h30;
                           u[n+4] = jtw_pkg::hex_digit({3'd0, ch[4]});
                           u[n+5] = jtw_pkg::hex_digit(ch[3:0]);
                           n = n + 4'd6;
                        end else begin
                           u[n] = ch; n = n + 4'd1;
                        end
                     end
                  endcase
               end
            end
            if (last_unit) begin
               if (kind != jtw_pkg::KIND_RAW) begin u[n] = 8'h22; n = n + 4'd1; end
               if (kind == jtw_pkg::KIND_NAME) begin
                  u[n] = 8'h3A; n = n + 4'd1;
                  if (pretty) begin u[n] = 8'h20; n = n + 4'd1; end
               end
               kind_in = jtw_pkg::KIND_NONE;
               if (level_ff == '0) last_event_in = jtw_pkg::EV_DONE;
               else last_event_in = (kind == jtw_pkg::KIND_NAME) ? jtw_pkg::EV_NAME
                                                                 : jtw_pkg::EV_VALUE;
            end
         end
      end else if (kind_ff != jtw_pkg::KIND_NONE) begin
         st = jtw_pkg::ST_BAD;
      end else begin
         unique case (req_type) inside
            jtw_pkg::TOK_OPEN_OBJ, jtw_pkg::TOK_OPEN_ARR: begin
               if (!val_ok) st = jtw_pkg::ST_BAD;
               else if (level_ff >= LW'(MAX_DEPTH)) st = jtw_pkg::ST_DEEP;
               else begin
                  if (comma) begin
                     u[n] = 8'h2C; n = n + 4'd1;
                     if (pretty) begin u[n] = 8'h20; n = n + 4'd1; end
                  end
                  u[n] = req_type[1] ? 8'h5B : 8'h7B; n = n + 4'd1;
                  push_en = 1'b1;
                  level_in = level_ff + LW'(1);
                  last_event_in = req_type[1] ? jtw_pkg::EV_SARR : jtw_pkg::EV_SOBJ;
               end
            end
            jtw_pkg::TOK_CLOSE_OBJ, jtw_pkg::TOK_CLOSE_ARR: begin
               if (req_type[1] ? !top_arr : !nm_ok) st = jtw_pkg::ST_BAD;
               else begin
                  u[n] = req_type[1] ? 8'h5D : 8'h7D; n = n + 4'd1;
                  level_in = level_ff - LW'(1);
                  lvl_zero_after = (level_in == '0);
                  last_event_in = lvl_zero_after ? jtw_pkg::EV_DONE
                                : (req_type[1] ? jtw_pkg::EV_EARR : jtw_pkg::EV_EOBJ);
               end
            end
            default: begin
               if (!val_ok) st = jtw_pkg::ST_BAD;
               else begin
                  if (comma) begin
                     u[n] = 8'h2C; n = n + 4'd1;
                     if (pretty) begin u[n] = 8'h20; n = n + 4'd1; end
                  end
                  if (req_type == jtw_pkg::TOK_TRUE) begin
                     u[n] = 8'h74; u[n+1] = 8'h72; u[n+2] = 8'h75; u[n+3] = 8'h65;
                     n = n + 4'd4;
                  end else if (req_type == jtw_pkg::TOK_FALSE) begin
                     u[n] = 8'h66; u[n+1] = 8'h61; u[n+2] = 8'h6C; u[n+3] = 8'h73;
                     u[n+4] = 8'h65; n = n + 4'd5;
                  end else begin
                     u[n] = 8'h6E; u[n+1] = 8'h75; u[n+2] = 8'h6C; u[n+3] = 8'h6C;
                     n = n + 4'd4;
                  end
                  last_event_in = (level_ff == '0) ? jtw_pkg::EV_DONE : jtw_pkg::EV_VALUE;
               end
            end
         endcase
      end
      if (st != jtw_pkg::ST_OK) begin
         n = '0;
         last_event_in = last_event_ff;
         kind_in = kind_ff;
         level_in = level_ff;
         push_en = 1'b0;
      end
      for (int i = 0; i < jtw_pkg::MaxUnits; i++) run.units[i] = u[i];
      run.count  = n;
      run.status = st;
      run.done   = (st == jtw_pkg::ST_OK) && (last_event_in == jtw_pkg::EV_DONE);
   end

   // writer state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_event_ff <= jtw_pkg::EV_NONE;
         kind_ff       <= jtw_pkg::KIND_NONE;
         level_ff      <= '0;
      end else if (take) begin
         last_event_ff <= last_event_in;
         kind_ff       <= kind_in;
         level_ff      <= level_in;
      end
   end

   // nesting stack, no reset
   always_ff @(posedge clock) begin
      if (take && push_en) stack_ff[wr_idx] <= req_type[1];
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(MAX_DEPTH)) else $error("nesting level overflow");
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      (last_event_ff == jtw_pkg::EV_DONE) |=> (last_event_ff == jtw_pkg::EV_DONE))
      else $error("document completion lost");
   a_done_level: assert property (@(posedge clock) disable iff (reset)
      (last_event_ff == jtw_pkg::EV_DONE) |-> (level_ff == '0))
      else $error("complete with open containers");
endmodule
`default_nettype wire

// ===== rtl/jtw_back.sv =====
`default_nettype none
module jtw_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire jtw_pkg::run_type run,
   output logic              empty,
   input  wire logic         pop,
   output logic [7:0]        out_unit,
   output logic              unit_valid,
   output logic              last_of_run,
   output logic [1:0]        status,
   output logic              doc_complete
);
   localparam int D  = jtw_pkg::QueueDepth;
   localparam int AW = $clog2(D);

   jtw_pkg::run_type q_ff [D];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic [3:0]    pos_ff;
   logic          do_pop, run_end;
   jtw_pkg::run_type head;

   assign head   = q_ff[rp_ff];
   assign full   = (cnt_ff == (AW+1)'(D));
   assign empty  = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign run_end = (head.count == 4'd0) || (pos_ff == head.count - 4'd1);

   // current character of the head run
   always_comb begin
      out_unit     = (head.count == 4'd0) ? 8'h00 : head.units[pos_ff];
      unit_valid   = (head.count != 4'd0);
      last_of_run  = run_end;
      status       = head.status;
      doc_complete = head.done;
   end

   // run queue payload
   always_ff @(posedge clock) begin
      if (push && !full) q_ff[wp_ff] <= run;
   end

   // queue pointers and character position
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0; pos_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= wp_ff + AW'(1);
         if (do_pop) begin
            if (run_end) begin
               rp_ff  <= rp_ff + AW'(1);
               pos_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 4'd1;
            end
         end
         cnt_ff <= cnt_ff + (AW+1)'(push && !full) - (AW+1)'(do_pop && run_end);
      end
   end

   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      empty |-> (pos_ff == 4'd0)) else $error("position set with empty queue");
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (pos_ff < 4'(jtw_pkg::MaxUnits))) else $error("position past run");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (pos_ff == $past(pos_ff))) else $error("position moved");
endmodule
`default_nettype wire

// ===== rtl/json_token_writer_with_escape.sv =====
`default_nettype none
// channel   | ports                                  | handshake
// request   | req_type code_unit has/first/last_unit | push, full
// response  | rsp_out_unit unit_valid last_of_run ...| pop, empty
// csr       | csr_pretty_spaces                      | csr_write
// An item is classified in the cycle it is pushed; a sustained rate of one
// item per cycle while each item gives one character and pop stays high.
// A result run of n characters occupies the output for n pop beats, so an item
// with an escape gives up to twelve characters. A four-entry run queue lets
// the front take items while the output stalls; full rises when it holds four
// runs. Reset is synchronous and clears all but the stack and queue payload.
module json_token_writer_with_escape #(
   parameter int MAX_DEPTH  = jtw_pkg::MaxDepthDefault,
   parameter int CHAR_WIDTH = jtw_pkg::CharWidthDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic                  csr_pretty_spaces,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [3:0]            req_type,
   input  wire logic [CHAR_WIDTH-1:0] req_code_unit,
   input  wire logic                  req_has_unit,
   input  wire logic                  req_first_unit,
   input  wire logic                  req_last_unit,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [7:0]                 rsp_out_unit,
   output logic                       rsp_unit_valid,
   output logic                       rsp_last_of_run,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_doc_complete
);
   logic pretty_ff;
   jtw_pkg::run_type run;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) pretty_ff <= 1'b0;
      else if (csr_write) pretty_ff <= csr_pretty_spaces;
   end

   jtw_front #(.MAX_DEPTH(MAX_DEPTH), .CHAR_WIDTH(CHAR_WIDTH)) u_front (
      .clock, .reset, .pretty(pretty_ff), .take(push && !full),
      .req_type, .code_unit(req_code_unit), .has_unit(req_has_unit),
      .first_unit(req_first_unit), .last_unit(req_last_unit), .run
   );

   jtw_back u_back (
      .clock, .reset, .push, .full, .run, .empty, .pop,
      .out_unit(rsp_out_unit), .unit_valid(rsp_unit_valid),
      .last_of_run(rsp_last_of_run), .status(rsp_status),
      .doc_complete(rsp_doc_complete)
   );
endmodule
`default_nettype wire

// ===== sim/tb_json_token_writer_with_escape.sv =====
`timescale 1ns / 1ps
module tb_json_token_writer_with_escape;

   // one output beat as seen on the rsp_ ports
   typedef struct {
      logic [7:0] unit;
      logic       valid;
      logic       last;
      logic [1:0] status;
      logic       done;
   } char_beat_type;

   // directed stimulus row; chk marks rows whose first beat is typed in
   typedef struct {
      logic [3:0] tok;
      logic [7:0] ch;
      logic       has, first, last;
      logic       chk;
      logic [1:0] status;
      logic [7:0] unit;
   } token_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write = 1'b0;
   logic       csr_pretty_spaces = 1'b0;
   logic       push = 1'b0;
   logic       full;
   logic [3:0] req_type = '0;
   logic [7:0] req_code_unit = '0;
   logic       req_has_unit = 1'b0;
   logic       req_first_unit = 1'b0;
   logic       req_last_unit = 1'b0;
   logic       empty;
   logic       pop = 1'b0;
   logic [7:0] rsp_out_unit;
   logic       rsp_unit_valid;
   logic       rsp_last_of_run;
   logic [1:0] rsp_status;
   logic       rsp_doc_complete;

   // writer state kept by the predictor
   logic               p_pretty;
   jtw_pkg::event_type p_ev;
   logic               p_stack [jtw_pkg::MaxDepthDefault];
   int                 p_lvl;
   jtw_pkg::kind_type  p_open;
   logic [7:0]         text_buf [$];

   char_beat_type text_q [$];
   int         send_idle = 0;
   int         recv_stall = 0;
   int         errors = 0;
   int         n_items = 0;
   int         n_beats = 0;
   int         n_rejects = 0;
   int         max_lvl = 0;
   bit         done_seen = 1'b0;

   json_token_writer_with_escape dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_pretty_spaces(csr_pretty_spaces),
      .push(push), .full(full),
      .req_type(req_type), .req_code_unit(req_code_unit), .req_has_unit(req_has_unit),
      .req_first_unit(req_first_unit), .req_last_unit(req_last_unit),
      .empty(empty), .pop(pop),
      .rsp_out_unit(rsp_out_unit), .rsp_unit_valid(rsp_unit_valid),
      .rsp_last_of_run(rsp_last_of_run), .rsp_status(rsp_status),
      .rsp_doc_complete(rsp_doc_complete)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
   endtask

   // ---------------- predictor ----------------
   function automatic bit top_is_arr();
      return p_lvl > 0 && p_stack[p_lvl-1];
   endfunction

   function automatic bit value_ok();
      case (p_ev) inside
         jtw_pkg::EV_NONE, jtw_pkg::EV_NAME, jtw_pkg::EV_SARR: return 1'b1;
         jtw_pkg::EV_EARR, jtw_pkg::EV_EOBJ, jtw_pkg::EV_VALUE: return top_is_arr();
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit name_ok();
      return p_lvl > 0 && !top_is_arr() && p_ev != jtw_pkg::EV_NAME;
   endfunction

   function automatic void put_comma();
      if (p_ev == jtw_pkg::EV_EARR || p_ev == jtw_pkg::EV_EOBJ || p_ev == jtw_pkg::EV_VALUE)
      begin
         text_buf.push_back(",");
         if (p_pretty) text_buf.push_back(" ");
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v <= 4'd9) ? 8'h30 + v : 8'h41 + (v - 4'd10);
   endfunction

   function automatic void put_escaped(input logic [7:0] c);
      case (c)
         8'h22: begin text_buf.push_back("\\"); text_buf.push_back("\""); end
         8'h5C: begin text_buf.push_back("\\"); text_buf.push_back("\\"); end
         8'h08: begin text_buf.push_back("\\"); text_buf.push_back("b"); end
         8'h0C: begin text_buf.push_back("\\"); text_buf.push_back("f"); end
         8'h0A: begin text_buf.push_back("\\"); text_buf.push_back("n"); end
         8'h0D: begin text_buf.push_back("\\"); text_buf.push_back("r"); end
         8'h09: begin text_buf.push_back("\\"); text_buf.push_back("t"); end
         default: begin
            if (c <= 8'h1F) begin
               text_buf.push_back("\\");
               text_buf.push_back("u");
               text_buf.push_back("0");
               text_buf.push_back("0");
               text_buf.push_back(hex_char(c[7:4]));
               text_buf.push_back(hex_char(c[3:0]));
            end else begin
               text_buf.push_back(c);
            end
         end
      endcase
   endfunction

   function automatic void close_event(input jtw_pkg::event_type e);
      p_ev = (p_lvl == 0) ? jtw_pkg::EV_DONE : e;
   endfunction

   // applies one token to the writer state, fills text_buf, returns status
   function automatic logic [1:0] writer_step(input logic [3:0] t, input logic [7:0] c,
                                              input logic h, input logic f, input logic l);
      jtw_pkg::kind_type k;
      string    w;
      if (p_ev == jtw_pkg::EV_DONE) return jtw_pkg::ST_DONE;
      if (t > jtw_pkg::TOK_NULL) return jtw_pkg::ST_BAD;
      if (t >= jtw_pkg::TOK_NAME && t <= jtw_pkg::TOK_RAW) begin
         k = jtw_pkg::kind_type'(t - 4'd3);
         if (f) begin
            if (p_open != jtw_pkg::KIND_NONE) return jtw_pkg::ST_BAD;
            if (k == jtw_pkg::KIND_NAME ? !name_ok() : !value_ok()) return jtw_pkg::ST_BAD;
            put_comma();
            if (k != jtw_pkg::KIND_RAW) text_buf.push_back("\"");
            p_open = k;
         end else if (p_open != k) begin
            return jtw_pkg::ST_BAD;
         end
         if (h) begin
            if (k == jtw_pkg::KIND_RAW) text_buf.push_back(c);
            else put_escaped(c);
         end
         if (l) begin
            if (k != jtw_pkg::KIND_RAW) text_buf.push_back("\"");
            if (k == jtw_pkg::KIND_NAME) begin
               text_buf.push_back(":");
               if (p_pretty) text_buf.push_back(" ");
            end
            p_open = jtw_pkg::KIND_NONE;
            close_event(k == jtw_pkg::KIND_NAME ? jtw_pkg::EV_NAME : jtw_pkg::EV_VALUE);
         end
         return jtw_pkg::ST_OK;
      end
      if (p_open != jtw_pkg::KIND_NONE) return jtw_pkg::ST_BAD;
      case (t) inside
         jtw_pkg::TOK_OPEN_OBJ, jtw_pkg::TOK_OPEN_ARR: begin
            if (!value_ok()) return jtw_pkg::ST_BAD;
            if (p_lvl >= jtw_pkg::MaxDepthDefault) return jtw_pkg::ST_DEEP;
            put_comma();
            text_buf.push_back(t == jtw_pkg::TOK_OPEN_OBJ ? "{" : "[");
            p_stack[p_lvl] = (t == jtw_pkg::TOK_OPEN_ARR);
            p_lvl++;
            close_event(t == jtw_pkg::TOK_OPEN_OBJ ? jtw_pkg::EV_SOBJ : jtw_pkg::EV_SARR);
         end
         jtw_pkg::TOK_CLOSE_OBJ: begin
            if (!name_ok()) return jtw_pkg::ST_BAD;
            text_buf.push_back("}");
            p_lvl--;
            close_event(jtw_pkg::EV_EOBJ);
         end
         jtw_pkg::TOK_CLOSE_ARR: begin
            if (!top_is_arr()) return jtw_pkg::ST_BAD;
            text_buf.push_back("]");
            p_lvl--;
            close_event(jtw_pkg::EV_EARR);
         end
         default: begin
            if (!value_ok()) return jtw_pkg::ST_BAD;
            put_comma();
            w = (t == jtw_pkg::TOK_TRUE) ? "true" : (t == jtw_pkg::TOK_FALSE) ? "false"
                                                                              : "null";
            for (int i = 0; i < w.len(); i++) text_buf.push_back(w[i]);
            close_event(jtw_pkg::EV_VALUE);
         end
      endcase
      return jtw_pkg::ST_OK;
   endfunction

   // predicts the beats of one accepted token and queues them
   task automatic predict_text(input logic [3:0] t, input logic [7:0] c, input logic h,
                               input logic f, input logic l, output char_beat_type first_beat);
      jtw_pkg::event_type was;
      logic [1:0] st;
      logic       dn;
      char_beat_type b;
      was = p_ev;
      text_buf.delete();
      st = writer_step(t, c, h, f, l);
      if (st != jtw_pkg::ST_OK) begin
         text_buf.delete();
         n_rejects++;
      end
      dn = (st == jtw_pkg::ST_OK && was != jtw_pkg::EV_DONE && p_ev == jtw_pkg::EV_DONE);
      if (dn) done_seen = 1'b1;
      if (p_lvl > max_lvl) max_lvl = p_lvl;
      if (text_buf.size() == 0) begin
         b = '{unit: 8'h00, valid: 1'b0, last: 1'b1, status: st, done: dn};
         text_q.push_back(b);
         first_beat = b;
      end else begin
         foreach (text_buf[i]) begin
            b = '{unit: text_buf[i], valid: 1'b1, last: (i == text_buf.size() - 1),
                  status: st, done: dn};
            text_q.push_back(b);
            if (i == 0) first_beat = b;
         end
      end
   endtask

   // ---------------- driving ----------------
   task automatic send_token(input logic [3:0] t, input logic [7:0] c, input logic h,
                             input logic f, input logic l, output char_beat_type first_beat);
      while ($urandom_range(99) < send_idle) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_type = t;
      req_code_unit = c;
      req_has_unit = h;
      req_first_unit = f;
      req_last_unit = l;
      do @(posedge clock); while (full);
      predict_text(t, c, h, f, l, first_beat);
      n_items++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      push = 1'b0;
      while (text_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_spacing(input logic v);
      wait_drained();
      csr_write = 1'b1;
      csr_pretty_spaces = v;
      @(negedge clock);
      csr_write = 1'b0;
      p_pretty = v;
   endtask

   // ends any open token, gives a dangling name a value and closes containers down to the given level
   task automatic settle_to(input int target);
      char_beat_type fb;
      if (p_open != jtw_pkg::KIND_NONE)
         send_token(4'(p_open) + 4'd3, "z", 1'b1, 1'b0, 1'b1, fb);
      if (p_ev == jtw_pkg::EV_NAME)
         send_token(jtw_pkg::TOK_NULL, 8'h00, 1'b0, 1'b0, 1'b0, fb);
      while (p_lvl > target)
         send_token(top_is_arr() ? jtw_pkg::TOK_CLOSE_ARR : jtw_pkg::TOK_CLOSE_OBJ,
                    8'h00, 1'b0, 1'b0, 1'b0, fb);
   endtask

   // mostly well-formed tokens with random content, some noise
   task automatic pick_token(output logic [3:0] t, output logic [7:0] c, output logic h,
                             output logic f, output logic l);
      logic [7:0] specials [12] = '{8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D,
                                    8'h09, 8'h00, 8'h1F, 8'h7F, 8'h80, 8'hFF};
      int r;
      c = ($urandom_range(9) < 3) ? specials[$urandom_range(11)] : 8'($urandom_range(255));
      h = ($urandom_range(15) != 0);
      f = 1'b0;
      l = 1'b0;
      t = jtw_pkg::TOK_NULL;
      if ($urandom_range(9) == 0) begin
         t = 4'($urandom_range(15));
         f = 1'($urandom_range(1));
         l = 1'($urandom_range(1));
         h = 1'($urandom_range(1));
         // keep the top-level array open
         if (t == jtw_pkg::TOK_CLOSE_ARR && p_lvl == 1) t = jtw_pkg::TOK_NULL;
      end else if (p_open != jtw_pkg::KIND_NONE) begin
         t = 4'(p_open) + 4'd3;
         l = ($urandom_range(3) == 0);
      end else begin
         f = 1'b1;
         l = ($urandom_range(2) == 0);
         if (name_ok()) begin
            t = (p_lvl > 1 && $urandom_range(4) == 0) ? jtw_pkg::TOK_CLOSE_OBJ
                                                       : jtw_pkg::TOK_NAME;
         end else begin
            r = $urandom_range(9);
            case (r) inside
               0: t = (p_lvl < 6) ? jtw_pkg::TOK_OPEN_OBJ : jtw_pkg::TOK_NULL;
               1: t = (p_lvl < 6) ? jtw_pkg::TOK_OPEN_ARR : jtw_pkg::TOK_TRUE;
               2: t = jtw_pkg::TOK_STRING;
               3, 4: t = jtw_pkg::TOK_RAW;
               5: t = jtw_pkg::TOK_TRUE;
               6: t = jtw_pkg::TOK_FALSE;
               7: t = jtw_pkg::TOK_NULL;
               default: t = (p_ev != jtw_pkg::EV_NAME && p_lvl > 1) ? jtw_pkg::TOK_CLOSE_ARR
                                                                     : jtw_pkg::TOK_STRING;
            endcase
         end
      end
   endtask

   task automatic random_phase(input int items, input bit hold_mid);
      logic [3:0] t;
      logic [7:0] c;
      logic       h, f, l;
      char_beat_type fb;
      for (int i = 0; i < items; i++) begin
         if (hold_mid && i == items / 2) wait_drained();
         pick_token(t, c, h, f, l);
         send_token(t, c, h, f, l, fb);
      end
   endtask

   // ---------------- checking ----------------
   always @(negedge clock) begin
      if (reset) pop <= 1'b0;
      else pop <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && pop && !empty) begin
         n_beats++;
         if (text_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_out_unit, 0);
         end else begin
            want = text_q.pop_front();
            if (rsp_unit_valid !== want.valid)
               report_mismatch("unit_valid", rsp_unit_valid, want.valid);
            if (rsp_out_unit !== want.unit) report_mismatch("out_unit", rsp_out_unit, want.unit);
            if (rsp_last_of_run !== want.last)
               report_mismatch("last_of_run", rsp_last_of_run, want.last);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_doc_complete !== want.done)
               report_mismatch("doc_complete", rsp_doc_complete, want.done);
         end
      end
   end

   // ---------------- stimulus ----------------
   token_row_type opening [24] = '{
      '{jtw_pkg::TOK_CLOSE_OBJ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{jtw_pkg::TOK_RAW,       8'h31, 1'b1, 1'b0, 1'b1, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{jtw_pkg::TOK_OPEN_ARR,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  "["},
      '{jtw_pkg::TOK_STRING,    8'h22, 1'b1, 1'b1, 1'b0, 1'b1, jtw_pkg::ST_OK,  "\""},
      '{jtw_pkg::TOK_STRING,    8'h00, 1'b1, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  "\\"},
      '{jtw_pkg::TOK_STRING,    8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  8'hFF},
      '{jtw_pkg::TOK_STRING,    8'h41, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  8'h00},
      '{jtw_pkg::TOK_OPEN_OBJ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{jtw_pkg::TOK_STRING,    8'h1F, 1'b1, 1'b0, 1'b1, 1'b1, jtw_pkg::ST_OK,  "\\"},
      '{jtw_pkg::TOK_RAW,       8'h80, 1'b1, 1'b1, 1'b1, 1'b1, jtw_pkg::ST_OK,  ","},
      '{jtw_pkg::TOK_NAME,      8'h61, 1'b1, 1'b1, 1'b1, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{4'd15,                  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{jtw_pkg::TOK_OPEN_OBJ,  8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  ","},
      '{jtw_pkg::TOK_NAME,      8'h0A, 1'b1, 1'b1, 1'b1, 1'b1, jtw_pkg::ST_OK,  "\""},
      '{jtw_pkg::TOK_CLOSE_OBJ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{jtw_pkg::TOK_NULL,      8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  "n"},
      '{jtw_pkg::TOK_NAME,      8'h5C, 1'b1, 1'b1, 1'b0, 1'b1, jtw_pkg::ST_OK,  ","},
      '{jtw_pkg::TOK_STRING,    8'h62, 1'b1, 1'b1, 1'b0, 1'b1, jtw_pkg::ST_BAD, 8'h00},
      '{jtw_pkg::TOK_NAME,      8'h09, 1'b1, 1'b0, 1'b1, 1'b1, jtw_pkg::ST_OK,  "\\"},
      '{jtw_pkg::TOK_FALSE,     8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  "f"},
      '{jtw_pkg::TOK_CLOSE_OBJ, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_OK,  "}"},
      '{jtw_pkg::TOK_TRUE,      8'h00, 1'b0, 1'b0, 1'b0, 1'b0, jtw_pkg::ST_OK,  8'h00},
      '{jtw_pkg::TOK_STRING,    8'h7E, 1'b0, 1'b1, 1'b1, 1'b0, jtw_pkg::ST_OK,  8'h00},
      '{4'd10,                  8'h0D, 1'b1, 1'b0, 1'b0, 1'b1, jtw_pkg::ST_BAD, 8'h00}
   };

   initial begin
      char_beat_type fb;
      p_pretty = 1'b0;
      p_ev = jtw_pkg::EV_NONE;
      p_lvl = 0;
      p_open = jtw_pkg::KIND_NONE;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening; the top-level array stays open until the end
      write_spacing(1'b0);
      foreach (opening[i]) begin
         send_token(opening[i].tok, opening[i].ch, opening[i].has, opening[i].first,
                    opening[i].last, fb);
         if (opening[i].chk && (fb.status !== opening[i].status || fb.unit !== opening[i].unit))
            report_mismatch($sformatf("opening row %0d", i), fb.unit, opening[i].unit);
      end

      // nest to full depth, one open too many, then unwind
      write_spacing(1'b1);
      settle_to(1);
      while (p_lvl < jtw_pkg::MaxDepthDefault)
         send_token(jtw_pkg::TOK_OPEN_ARR, 8'h00, 1'b0, 1'b0, 1'b0, fb);
      send_token(jtw_pkg::TOK_OPEN_OBJ, 8'h00, 1'b0, 1'b0, 1'b0, fb);
      if (fb.status !== jtw_pkg::ST_DEEP)
         report_mismatch("too deep status", fb.status, jtw_pkg::ST_DEEP);
      settle_to(1);

      // random phases with different idling and spacing
      random_phase(90, 1'b0);
      write_spacing(1'b0);
      send_idle = 81;
      recv_stall = 0;
      random_phase(90, 1'b0);
      write_spacing(1'b1);
      send_idle = 0;
      recv_stall = 81;
      random_phase(90, 1'b1);
      write_spacing(1'b0);
      send_idle = 38;
      recv_stall = 38;
      random_phase(90, 1'b0);

      // close the document, then tokens after completion
      settle_to(0);
      send_token(jtw_pkg::TOK_TRUE, 8'h00, 1'b0, 1'b0, 1'b0, fb);
      if (fb.status !== jtw_pkg::ST_DONE)
         report_mismatch("after complete", fb.status, jtw_pkg::ST_DONE);
      send_token(jtw_pkg::TOK_OPEN_ARR, 8'h00, 1'b0, 1'b0, 1'b0, fb);
      push = 1'b0;
      while (text_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d tokens, %0d output beats, %0d rejected, depth up to %0d",
               n_items, n_beats, n_rejects, max_lvl);
      $display("document closed: %0d, mismatches: %0d", done_seen, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #6000000;
      $display("timeout with %0d beats outstanding", text_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
